### design/tpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg - twin prime counter shared definitions
// Field widths, count limit and default candidate width.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int VALUE_W        = 20;
    localparam int COUNT_W        = 14;
    localparam int VALUE_BITS_DEF = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

### design/twin_prime_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twin_prime_counter_unit - trial division prime test with twin pair count
// Tests each candidate request for primality and counts twin prime pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_in_valid / o_in_ready carries i_value and i_clear.
//   Output channel o_out_valid / i_out_ready carries o_value_is_prime,
//   o_twin_found and o_twin_count, one result per request.
//   Trial divisors d = 2, 3, ... while d*d <= value; each remainder comes
//   from a bit-serial restoring divider, one quotient bit per cycle.
//   Run time grows with k, the number of divisors tried (up to about
//   sqrt(value)); the serial divider sets it.
//   One request is in work at a time; a new one is taken as soon as the
//   result has moved into the output register, even while that result is
//   still waiting for i_out_ready.
//   If the receiver stalls, the finished result holds in the block until
//   the output register frees up.
//   Reset clears the remembered prime, the pair count and the output valid.
//   i_clear drops the remembered prime and the pair count before the request.
// ----------------------------------------------------------------------------
module twin_prime_counter_unit #(
    parameter int VALUE_BITS = tpc_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tpc_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_clear,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_value_is_prime,
    output logic                        o_twin_found,
    output logic [tpc_pkg::COUNT_W-1:0] o_twin_count
);

    localparam int IN_BITS = (VALUE_BITS < tpc_pkg::VALUE_W) ? VALUE_BITS : tpc_pkg::VALUE_W;
    localparam int SQ_BITS = VALUE_BITS + 2;
    localparam int CNT_W   = $clog2(VALUE_BITS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                  r_state;
    logic [VALUE_BITS-1:0]       r_n;
    logic [VALUE_BITS-1:0]       r_shift;
    logic [VALUE_BITS-1:0]       r_rem;
    logic [VALUE_BITS-1:0]       r_d;
    logic [SQ_BITS-1:0]          r_sq;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_prime;
    logic [VALUE_BITS-1:0]       r_last;
    logic [tpc_pkg::COUNT_W-1:0] r_total;
    logic                        r_out_valid;
    logic                        r_out_prime;
    logic                        r_out_twin;
    logic [tpc_pkg::COUNT_W-1:0] r_out_count;

    logic [VALUE_BITS:0]         w_trial;
    logic [VALUE_BITS:0]         w_diff;
    logic [VALUE_BITS-1:0]       n_rem;
    logic [SQ_BITS-1:0]          w_n_ext;
    logic [SQ_BITS-1:0]          n_sq;
    logic                        w_twin;
    logic                        w_out_free;
    logic [tpc_pkg::COUNT_W-1:0] n_total;

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_value_is_prime = r_out_prime;
    assign o_twin_found     = r_out_twin;
    assign o_twin_count     = r_out_count;

    assign w_trial = {r_rem, r_shift[VALUE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign n_rem   = (w_trial >= {1'b0, r_d}) ? w_diff[VALUE_BITS-1:0]
                                              : w_trial[VALUE_BITS-1:0];
    assign w_n_ext = SQ_BITS'(r_n);
    assign n_sq    = r_sq + SQ_BITS'({r_d, 1'b0}) + SQ_BITS'(1);

    assign w_twin     = r_prime && (r_last != '0)
                     && ((VALUE_BITS+1)'(r_n) == (VALUE_BITS+1)'(r_last) + (VALUE_BITS+1)'(2));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign n_total    = (w_twin && (r_total != tpc_pkg::COUNT_MAX)) ? r_total + 1'b1 : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_n   <= VALUE_BITS'(i_value[IN_BITS-1:0]);
                        r_d   <= VALUE_BITS'(2);
                        r_sq  <= SQ_BITS'(4);
                        if (i_clear) begin
                            r_last  <= '0;
                            r_total <= '0;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_n < VALUE_BITS'(2)) begin
                        r_prime <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_sq > w_n_ext) begin
                        r_prime <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_shift <= r_n;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(VALUE_BITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
                    r_rem   <= n_rem;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        if (n_rem == '0) begin
                            r_prime <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_d     <= r_d + 1'b1;
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_prime <= r_prime;
                        r_out_twin  <= w_twin;
                        r_out_count <= n_total;
                        r_total     <= n_total;
                        if (r_prime) begin
                            r_last <= r_n;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/tpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_checker - port checks for the twin prime counter
// Watches the top-level ports and flags inconsistent behavior.
// ----------------------------------------------------------------------------
module tpc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        o_value_is_prime,
    input  logic                        o_twin_found,
    input  logic [tpc_pkg::COUNT_W-1:0] o_twin_count
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value_is_prime)
            && $stable(o_twin_found) && $stable(o_twin_count))
        else $error("stalled result changed");

    a_twin_is_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_twin_found |-> o_value_is_prime && (o_twin_count != '0))
        else $error("twin reported without prime or count");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a request");

endmodule

bind twin_prime_counter_unit tpc_checker u_tpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_value_is_prime (o_value_is_prime),
    .o_twin_found     (o_twin_found),
    .o_twin_count     (o_twin_count)
);

### tb/twin_prime_counter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twin_prime_counter_unit_test - self-checking bench for the twin prime counter
// Walks a table of directed requests, then sends random ascending odd runs
// mixed with noise. Every result is compared against a trial division prime
// test and a twin pair tally kept in the bench, or against the values typed in
// a directed row; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module twin_prime_counter_unit_test;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_REQUESTS = 80;
    localparam int DRAIN_CYCLES    = 100;
    localparam longint CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic                        is_prime;
        logic                        twin;
        logic [tpc_pkg::COUNT_W-1:0] count;
    } t_tally;

    typedef struct packed {
        logic [tpc_pkg::VALUE_W-1:0] value;
        logic                        clear;
        logic                        typed;
        t_tally                      tally;
    } t_request_row;

    localparam int DIRECTED_ROWS = 23;
    localparam t_request_row DIRECTED [DIRECTED_ROWS] = '{
        '{20'd0,       1'b0, 1'b1, '{1'b0, 1'b0, 14'd0}},
        '{20'd1,       1'b0, 1'b1, '{1'b0, 1'b0, 14'd0}},
        '{20'd2,       1'b0, 1'b1, '{1'b1, 1'b0, 14'd0}},
        '{20'd4,       1'b0, 1'b1, '{1'b0, 1'b0, 14'd0}},
        '{20'd3,       1'b0, 1'b0, '0},
        '{20'd5,       1'b0, 1'b0, '0},
        '{20'd7,       1'b0, 1'b0, '0},
        '{20'd9,       1'b0, 1'b0, '0},
        '{20'd25,      1'b0, 1'b0, '0},
        '{20'd29,      1'b0, 1'b0, '0},
        '{20'd31,      1'b0, 1'b0, '0},
        '{20'd49,      1'b0, 1'b0, '0},
        '{20'd1048575, 1'b1, 1'b1, '{1'b0, 1'b0, 14'd0}},
        '{20'd1048573, 1'b0, 1'b1, '{1'b1, 1'b0, 14'd0}},
        '{20'd7,       1'b0, 1'b0, '0},
        '{20'd5,       1'b0, 1'b0, '0},
        '{20'd7,       1'b0, 1'b0, '0},
        '{20'd3,       1'b1, 1'b0, '0},
        '{20'd5,       1'b0, 1'b0, '0},
        '{20'd2,       1'b1, 1'b0, '0},
        '{20'd0,       1'b1, 1'b1, '{1'b0, 1'b0, 14'd0}},
        '{20'd65536,   1'b0, 1'b0, '0},
        '{20'd65537,   1'b0, 1'b0, '0}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [tpc_pkg::VALUE_W-1:0] i_value;
    logic                        i_clear;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_value_is_prime;
    logic                        o_twin_found;
    logic [tpc_pkg::COUNT_W-1:0] o_twin_count;

    logic [tpc_pkg::VALUE_W-1:0] seen_prime;
    logic [tpc_pkg::COUNT_W-1:0] pair_tally;
    t_tally                      pending_tallies [$];
    int                          error_count = 0;
    bit                          idle_on = 1'b1;
    longint                      cycle_count = 0;

    twin_prime_counter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_value          (i_value),
        .i_clear          (i_clear),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_value_is_prime (o_value_is_prime),
        .o_twin_found     (o_twin_found),
        .o_twin_count     (o_twin_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit trial_division_prime(logic [tpc_pkg::VALUE_W-1:0] n);
        longint unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_tally tally_candidate(logic [tpc_pkg::VALUE_W-1:0] value,
                                               logic clear);
        t_tally t;
        if (clear) begin
            seen_prime = '0;
            pair_tally = '0;
        end
        t.is_prime = trial_division_prime(value);
        t.twin     = 1'b0;
        if (t.is_prime) begin
            if (seen_prime != 0 && {1'b0, value} == {1'b0, seen_prime} + 2) begin
                t.twin = 1'b1;
                if (pair_tally != tpc_pkg::COUNT_MAX) pair_tally = pair_tally + 1'b1;
            end
            seen_prime = value;
        end
        t.count = pair_tally;
        return t;
    endfunction

    task automatic send_request(input logic [tpc_pkg::VALUE_W-1:0] value, input logic clear,
                                input bit typed, input t_tally typed_tally);
        int     gap;
        t_tally predicted;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_clear    <= clear;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted = tally_candidate(value, clear);
        pending_tallies.push_back(typed ? typed_tally : predicted);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge i_clk);
    endtask

    // receiver: stall at random before each result
    initial begin
        int stall;
        i_out_ready = 1'b0;
        do @(negedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_tallies.size() == 0) begin
                $display("%0t: result with no request pending: prime=%0b twin=%0b count=%0d",
                         $time, o_value_is_prime, o_twin_found, o_twin_count);
                error_count++;
            end else begin
                want = pending_tallies.pop_front();
                if (o_value_is_prime !== want.is_prime) begin
                    $display("%0t: value_is_prime expected %0b actual %0b",
                             $time, want.is_prime, o_value_is_prime);
                    error_count++;
                end
                if (o_twin_found !== want.twin) begin
                    $display("%0t: twin_found expected %0b actual %0b",
                             $time, want.twin, o_twin_found);
                    error_count++;
                end
                if (o_twin_count !== want.count) begin
                    $display("%0t: twin_count expected %0d actual %0d",
                             $time, want.count, o_twin_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int                          issued;
        int                          kind;
        int                          len;
        bit                          paused;
        logic                        clr;
        logic [tpc_pkg::VALUE_W-1:0] start;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_value    = '0;
        i_clear    = 1'b0;
        seen_prime = '0;
        pair_tally = '0;
        issued     = 0;
        paused     = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(DIRECTED[r].value, DIRECTED[r].clear, DIRECTED[r].typed,
                         DIRECTED[r].tally);
        end
        wait_drained();

        while (issued < RANDOM_REQUESTS) begin
            if (!paused && issued >= RANDOM_REQUESTS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            idle_on = ($urandom_range(0, 4) != 0);
            kind    = $urandom_range(0, 9);
            if (kind <= 6) begin
                start = tpc_pkg::VALUE_W'($urandom_range(0, 1000) * 2 + 1);
                len   = $urandom_range(4, 12);
                clr   = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len && issued < RANDOM_REQUESTS; k++) begin
                    send_request(start + tpc_pkg::VALUE_W'(2 * k), clr && k == 0, 1'b0, '0);
                    issued++;
                end
            end else if (kind == 7) begin
                send_request(tpc_pkg::VALUE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
                issued++;
            end else if (kind == 8) begin
                send_request(tpc_pkg::VALUE_W'($urandom_range(0, 255)),
                             ($urandom_range(0, 7) == 0), 1'b0, '0);
                issued++;
            end else begin
                send_request({tpc_pkg::VALUE_W{1'b1}}
                             - tpc_pkg::VALUE_W'($urandom_range(0, 63)), 1'b0, 1'b0, '0);
                issued++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### twin_prime_counter_unit.f
design/tpc_pkg.sv
design/twin_prime_counter_unit.sv
design/tpc_checker.sv
tb/twin_prime_counter_unit_test.sv
